// ===== hdl/qconv_pkg.sv =====
// ---------------------------------------------------------------------------
// qconv_pkg
// Shared types and constants of the quantized 2-D convolution engine.
// ---------------------------------------------------------------------------
`default_nettype none

package qconv_pkg;

    localparam int ACT_DEPTH_DEF    = 65536;
    localparam int WEIGHT_DEPTH_DEF = 65536;
    localparam int MAX_OUT_CH_DEF   = 256;
    localparam int DATA_BITS_DEF    = 16;

    localparam logic [1:0] ACT_LOAD_ACT    = 2'd0;
    localparam logic [1:0] ACT_LOAD_WEIGHT = 2'd1;
    localparam logic [1:0] ACT_LOAD_BIAS   = 2'd2;
    localparam logic [1:0] ACT_COMPUTE     = 2'd3;

    localparam logic [2:0] REG_IN_HEIGHT    = 3'd0;
    localparam logic [2:0] REG_IN_WIDTH     = 3'd1;
    localparam logic [2:0] REG_IN_CHANNELS  = 3'd2;
    localparam logic [2:0] REG_OUT_CHANNELS = 3'd3;
    localparam logic [2:0] REG_KERNEL_SIZE  = 3'd4;
    localparam logic [2:0] REG_STRIDE       = 3'd5;
    localparam logic [2:0] REG_PADDING      = 3'd6;
    localparam logic [2:0] REG_DEQUANT      = 3'd7;

    localparam int PADDR_BITS = 6;
    localparam int PDATA_BITS = 64;

    typedef struct packed {
        logic [1:0]         action;
        logic [15:0]        index;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [15:0]        out_index;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hdl/quantized_conv2d_engine.sv =====
// ---------------------------------------------------------------------------
// quantized_conv2d_engine
// Quantized 2-D convolution: one output element per compute request.
// ---------------------------------------------------------------------------
// Load requests (activation, weight, bias) never stall the input. A
// compute request holds the input stalled while it runs: four 20-step
// divisions and a few multiplies locate the output element, then the
// tap walk reads one activation and weight pair per cycle from the
// stores, and a short tail scales, adds the bias and saturates. The
// result sits in an output register, so the next request is taken while
// it waits; a compute that ends while the previous result is still
// stalled there holds until that result leaves. An out-of-range index
// gives no result and ends early.
`default_nettype none

module quantized_conv2d_engine #(
    parameter int ACT_DEPTH    = qconv_pkg::ACT_DEPTH_DEF,
    parameter int WEIGHT_DEPTH = qconv_pkg::WEIGHT_DEPTH_DEF,
    parameter int MAX_OUT_CH   = qconv_pkg::MAX_OUT_CH_DEF,
    parameter int DATA_BITS    = qconv_pkg::DATA_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire qconv_pkg::t_in_item               i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output qconv_pkg::t_out_item                   o_out_item,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [qconv_pkg::PADDR_BITS-1:0]  paddr,
    input  wire logic [qconv_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [qconv_pkg::PDATA_BITS-1:0]       prdata,
    output logic                                   pready
);

    localparam int AW  = $clog2(ACT_DEPTH);
    localparam int WW  = $clog2(WEIGHT_DEPTH);
    localparam int BAW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
    localparam int DB  = DATA_BITS;
    localparam int DIVW = 20;

    typedef enum logic [4:0] {
        S_IDLE, S_DIV_OH, S_DIV_OW, S_PLANE, S_TOTAL, S_CHECK, S_DIV_O, S_DIV_HW,
        S_MUL_KK, S_MUL_CKK, S_MUL_WB, S_MUL_HS, S_MUL_WS, S_MUL_FH0W, S_MUL_HWP,
        S_TAP_INIT, S_TAPS, S_DRAIN, S_SUM, S_SCALE, S_BIAS, S_FIN
    } t_state;

    // configuration
    logic [8:0]  r_in_height, r_in_width, r_out_channels;
    logic [10:0] r_in_channels;
    logic [3:0]  r_kernel;
    logic [2:0]  r_stride, r_padding;
    logic [32:0] r_dequant;

    logic [DB-1:0] act_mem [ACT_DEPTH];
    logic [DB-1:0] wt_mem [WEIGHT_DEPTH];
    logic [31:0]   bias_mem [MAX_OUT_CH];

    t_state r_state;
    logic [15:0] r_idx;

    // shared divider
    logic [DIVW-1:0] r_dq, r_drem, r_dden;
    logic [4:0]      r_dcnt;
    logic [DIVW:0]   div_shift;
    logic            div_ge;
    logic [DIVW-1:0] div_rem_n;

    // shared setup multiplier
    logic signed [24:0] mul_a, mul_b;
    logic signed [49:0] r_mp;

    logic [9:0]  r_oh, r_ow, r_h, r_w;
    logic [19:0] r_plane;
    logic [8:0]  r_o;
    logic signed [13:0] r_fh0, r_fw0;
    logic signed [24:0] r_fh0w, r_rowoff;
    logic [17:0] r_hw;
    logic [30:0] r_cbase;
    logic [29:0] r_waddr;
    logic [10:0] r_c;
    logic [3:0]  r_kh, r_kw;

    // tap pipeline
    logic                 r_p1_v, r_p1_ok, r_p2_v;
    logic signed [DB-1:0] r_act_q, r_wt_q;
    logic signed [2*DB-1:0] r_prod;
    logic signed [63:0]   r_acc;
    logic signed [64:0]   acc_sum;

    logic signed [31:0] r_sum;
    logic [63:0]        r_sp;
    logic [31:0]        r_bias_q;
    logic               r_out_valid;
    qconv_pkg::t_out_item r_out;

    logic [2:0]  st_eff;
    logic [9:0]  span_h, span_w;
    logic        neg_h, neg_w;
    logic signed [14:0] fh, fw;
    logic        inmap, a_ok, w_ok, last_kw, last_kh, last_c;
    logic signed [33:0] aaddr;
    logic [31:0] idx_ext;
    logic        in_acc, out_acc, cfg_wr;
    logic [31:0] mag;
    logic [47:0] rounded;
    logic signed [49:0] scaled, total;
    logic signed [31:0] bias_v;

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign idx_ext = 32'(i_in_item.index);

    assign st_eff = (r_stride == 3'd0) ? 3'd1 : r_stride;
    assign span_h = 10'(r_in_height) + 10'({r_padding, 1'b0});
    assign span_w = 10'(r_in_width) + 10'({r_padding, 1'b0});
    assign neg_h  = span_h < 10'(r_kernel);
    assign neg_w  = span_w < 10'(r_kernel);

    assign div_shift = {r_drem, r_dq[DIVW-1]};
    assign div_ge    = div_shift >= {1'b0, r_dden};
    assign div_rem_n = div_ge ? DIVW'(div_shift - {1'b0, r_dden}) : div_shift[DIVW-1:0];

    assign fh = 15'(r_fh0) + $signed({11'b0, r_kh});
    assign fw = 15'(r_fw0) + $signed({11'b0, r_kw});
    assign inmap = (fh >= 0) && (fh < $signed({6'b0, r_in_height}))
                && (fw >= 0) && (fw < $signed({6'b0, r_in_width}));
    assign aaddr = $signed({3'b0, r_cbase}) + 34'(r_rowoff) + 34'(fw);
    assign a_ok  = inmap && ($unsigned(aaddr) < 34'(ACT_DEPTH));
    assign w_ok  = {2'b0, r_waddr} < 32'(WEIGHT_DEPTH);
    assign last_kw = r_kw == r_kernel - 4'd1;
    assign last_kh = r_kh == r_kernel - 4'd1;
    assign last_c  = r_c == r_in_channels - 11'd1;

    assign acc_sum = 65'(r_acc) + 65'(r_prod);

    assign mag     = r_sum[31] ? 32'(-r_sum) : 32'(r_sum);
    assign rounded = 48'((r_sp + 64'h8000) >> 16);
    assign scaled  = r_sum[31] ? -$signed({2'b0, rounded}) : $signed({2'b0, rounded});
    assign bias_v  = (32'(r_o) < 32'(MAX_OUT_CH)) ? $signed(r_bias_q) : 32'sd0;
    assign total   = scaled + 50'(bias_v);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_PLANE: begin
                mul_a = $signed(25'(r_oh));
                mul_b = $signed(25'(r_ow));
            end
            S_TOTAL: begin
                mul_a = $signed(25'(r_out_channels));
                mul_b = $signed(25'(r_mp[19:0]));
            end
            S_MUL_KK: begin
                mul_a = $signed(25'(r_kernel));
                mul_b = $signed(25'(r_kernel));
            end
            S_MUL_CKK: begin
                mul_a = $signed(25'(r_in_channels));
                mul_b = $signed(25'(r_mp[7:0]));
            end
            S_MUL_WB: begin
                mul_a = $signed(25'(r_o));
                mul_b = $signed(25'(r_mp[18:0]));
            end
            S_MUL_HS: begin
                mul_a = $signed(25'(r_h));
                mul_b = $signed(25'(st_eff));
            end
            S_MUL_WS: begin
                mul_a = $signed(25'(r_w));
                mul_b = $signed(25'(st_eff));
            end
            S_MUL_FH0W: begin
                mul_a = 25'(r_fh0);
                mul_b = $signed(25'(r_in_width));
            end
            S_MUL_HWP: begin
                mul_a = $signed(25'(r_in_height));
                mul_b = $signed(25'(r_in_width));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        case (paddr[5:3])
            qconv_pkg::REG_IN_HEIGHT:    prdata = 64'(r_in_height);
            qconv_pkg::REG_IN_WIDTH:     prdata = 64'(r_in_width);
            qconv_pkg::REG_IN_CHANNELS:  prdata = 64'(r_in_channels);
            qconv_pkg::REG_OUT_CHANNELS: prdata = 64'(r_out_channels);
            qconv_pkg::REG_KERNEL_SIZE:  prdata = 64'(r_kernel);
            qconv_pkg::REG_STRIDE:       prdata = 64'(r_stride);
            qconv_pkg::REG_PADDING:      prdata = 64'(r_padding);
            qconv_pkg::REG_DEQUANT:      prdata = 64'(r_dequant);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_height    <= 9'd1;
            r_in_width     <= 9'd1;
            r_in_channels  <= 11'd1;
            r_out_channels <= 9'd1;
            r_kernel       <= 4'd1;
            r_stride       <= 3'd1;
            r_padding      <= 3'd0;
            r_dequant      <= 33'h1_0000_0000;
        end else if (cfg_wr) begin
            case (paddr[5:3])
                qconv_pkg::REG_IN_HEIGHT:    r_in_height    <= pwdata[8:0];
                qconv_pkg::REG_IN_WIDTH:     r_in_width     <= pwdata[8:0];
                qconv_pkg::REG_IN_CHANNELS:  r_in_channels  <= pwdata[10:0];
                qconv_pkg::REG_OUT_CHANNELS: r_out_channels <= pwdata[8:0];
                qconv_pkg::REG_KERNEL_SIZE:  r_kernel       <= pwdata[3:0];
                qconv_pkg::REG_STRIDE:       r_stride       <= pwdata[2:0];
                qconv_pkg::REG_PADDING:      r_padding      <= pwdata[2:0];
                qconv_pkg::REG_DEQUANT:      r_dequant      <= pwdata[32:0];
                default: begin
                end
            endcase
        end
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_item.action == qconv_pkg::ACT_LOAD_ACT
            && idx_ext < 32'(ACT_DEPTH)) begin
            act_mem[idx_ext[AW-1:0]] <= i_in_item.value[DB-1:0];
        end
        r_act_q <= act_mem[aaddr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_item.action == qconv_pkg::ACT_LOAD_WEIGHT
            && idx_ext < 32'(WEIGHT_DEPTH)) begin
            wt_mem[idx_ext[WW-1:0]] <= i_in_item.value[DB-1:0];
        end
        r_wt_q <= wt_mem[r_waddr[WW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_item.action == qconv_pkg::ACT_LOAD_BIAS
            && idx_ext < 32'(MAX_OUT_CH)) begin
            bias_mem[idx_ext[BAW-1:0]] <= i_in_item.value;
        end
        r_bias_q <= bias_mem[BAW'(32'(r_o))];
    end

    always_ff @(posedge i_clk) begin
        r_mp <= mul_a * mul_b;
        // signed product of the two store reads, zero for an out-of-range tap
        if (r_p1_ok) begin
            r_prod <= r_act_q * r_wt_q;
        end else begin
            r_prod <= '0;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_dcnt      <= '0;
            r_p1_v      <= 1'b0;
            r_p1_ok     <= 1'b0;
            r_p2_v      <= 1'b0;
        end else begin
            if (out_acc && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            if (r_dcnt != 5'd0) begin
                r_dq   <= {r_dq[DIVW-2:0], div_ge};
                r_drem <= div_rem_n;
                r_dcnt <= r_dcnt - 5'd1;
            end
            r_p2_v <= r_p1_v;
            if (r_p2_v) begin
                if (acc_sum[64] != acc_sum[63]) begin
                    r_acc <= acc_sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
                end else begin
                    r_acc <= acc_sum[63:0];
                end
            end
            r_p1_v  <= (r_state == S_TAPS);
            r_p1_ok <= (r_state == S_TAPS) && a_ok && w_ok;
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_item.action == qconv_pkg::ACT_COMPUTE) begin
                        r_idx   <= i_in_item.index;
                        r_dq    <= 20'(span_h - 10'(r_kernel));
                        r_drem  <= '0;
                        r_dden  <= 20'(st_eff);
                        r_dcnt  <= 5'(DIVW);
                        r_state <= S_DIV_OH;
                    end
                end
                S_DIV_OH: begin
                    if (r_dcnt == 5'd0) begin
                        r_oh    <= neg_h ? 10'd0 : r_dq[9:0] + 10'd1;
                        r_dq    <= 20'(span_w - 10'(r_kernel));
                        r_drem  <= '0;
                        r_dcnt  <= 5'(DIVW);
                        r_state <= S_DIV_OW;
                    end
                end
                S_DIV_OW: begin
                    if (r_dcnt == 5'd0) begin
                        r_ow    <= neg_w ? 10'd0 : r_dq[9:0] + 10'd1;
                        r_state <= S_PLANE;
                    end
                end
                S_PLANE: r_state <= S_TOTAL;
                S_TOTAL: begin
                    r_plane <= r_mp[19:0];
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_plane == 20'd0 || 29'(r_idx) >= r_mp[28:0]) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_dq    <= 20'(r_idx);
                        r_drem  <= '0;
                        r_dden  <= r_plane;
                        r_dcnt  <= 5'(DIVW);
                        r_state <= S_DIV_O;
                    end
                end
                S_DIV_O: begin
                    if (r_dcnt == 5'd0) begin
                        r_o     <= r_dq[8:0];
                        r_dq    <= r_drem;
                        r_drem  <= '0;
                        r_dden  <= 20'(r_ow);
                        r_dcnt  <= 5'(DIVW);
                        r_state <= S_DIV_HW;
                    end
                end
                S_DIV_HW: begin
                    if (r_dcnt == 5'd0) begin
                        r_h     <= r_dq[9:0];
                        r_w     <= r_drem[9:0];
                        r_state <= S_MUL_KK;
                    end
                end
                S_MUL_KK:  r_state <= S_MUL_CKK;
                S_MUL_CKK: r_state <= S_MUL_WB;
                S_MUL_WB:  r_state <= S_MUL_HS;
                S_MUL_HS: begin
                    r_waddr <= r_mp[29:0];
                    r_state <= S_MUL_WS;
                end
                S_MUL_WS: begin
                    r_fh0   <= 14'(r_mp) - 14'(r_padding);
                    r_state <= S_MUL_FH0W;
                end
                S_MUL_FH0W: begin
                    r_fw0   <= 14'(r_mp) - 14'(r_padding);
                    r_state <= S_MUL_HWP;
                end
                S_MUL_HWP: begin
                    r_fh0w  <= 25'(r_mp);
                    r_state <= S_TAP_INIT;
                end
                S_TAP_INIT: begin
                    r_hw     <= r_mp[17:0];
                    r_rowoff <= r_fh0w;
                    r_cbase  <= '0;
                    r_c      <= '0;
                    r_kh     <= '0;
                    r_kw     <= '0;
                    r_acc    <= '0;
                    // no channels or no kernel: empty sum
                    if (r_in_channels == 11'd0 || r_kernel == 4'd0) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_state <= S_TAPS;
                    end
                end
                S_TAPS: begin
                    r_waddr <= r_waddr + 30'd1;
                    if (!last_kw) begin
                        r_kw <= r_kw + 4'd1;
                    end else begin
                        r_kw <= '0;
                        if (!last_kh) begin
                            r_kh     <= r_kh + 4'd1;
                            r_rowoff <= r_rowoff + 25'(r_in_width);
                        end else begin
                            r_kh     <= '0;
                            r_rowoff <= r_fh0w;
                            r_c      <= r_c + 11'd1;
                            r_cbase  <= r_cbase + 31'(r_hw);
                            if (last_c) begin
                                r_state <= S_DRAIN;
                            end
                        end
                    end
                end
                S_DRAIN: begin
                    if (!r_p1_v && !r_p2_v) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_acc > 64'sh7FFF_FFFF) begin
                        r_sum <= 32'sh7FFF_FFFF;
                    end else if (r_acc < -64'sh8000_0000) begin
                        r_sum <= 32'sh8000_0000;
                    end else begin
                        r_sum <= r_acc[31:0];
                    end
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_sp    <= 64'(mag * r_dequant);
                    r_state <= S_BIAS;
                end
                S_BIAS: begin
                    if (total > 50'sh7FFF_FFFF) begin
                        r_sum <= 32'sh7FFF_FFFF;
                    end else if (total < -50'sh8000_0000) begin
                        r_sum <= 32'sh8000_0000;
                    end else begin
                        r_sum <= total[31:0];
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.out_value <= r_sum;
                        r_out.out_index <= r_idx;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/qconv_checker.sv =====
// ---------------------------------------------------------------------------
// qconv_checker
// Port-level checks of the convolution engine, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

module qconv_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire qconv_pkg::t_in_item  i_in_item,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire qconv_pkg::t_out_item o_out_item
);

    // a compute request holds the input side
    a_compute_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_item.action == qconv_pkg::ACT_COMPUTE)
        |=> o_in_stall)
        else $error("compute request did not stall the input");

    // loads leave the input unstalled
    a_load_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_item.action != qconv_pkg::ACT_COMPUTE)
        |=> !o_in_stall)
        else $error("load request stalled the input");

    // a new result appears exactly as the compute ends
    a_result_ends_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $fell(o_in_stall))
        else $error("result appeared outside the end of a compute");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind quantized_conv2d_engine qconv_checker u_qconv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
